>>> rtl/pip_pkg.sv
// shared constants and types of the point-in-polygon winding block
package pip_pkg;

  // polygon store size and derived widths
  localparam int MAX_VERTICES = 256;
  localparam int MIN_POLY     = 3;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int ACC_W        = CNT_W + 1;

  // field widths of the item and result beats
  localparam int COORD_W = 32;
  localparam int KIND_W  = 2;
  localparam int SUM_W   = 10;
  localparam int TOTAL_W = 9;

  // edge arithmetic widths
  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = 2 * DIFF_W;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  // per-edge contributions
  localparam logic signed [1:0] TURN_ZERO = 2'sb00;
  localparam logic signed [1:0] TURN_POS  = 2'sb01;
  localparam logic signed [1:0] TURN_NEG  = 2'sb11;

  // request to the edge unit: one edge and the query point
  typedef struct packed {
    logic                      start;
    logic signed [COORD_W-1:0] x0;
    logic signed [COORD_W-1:0] y0;
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
  } edge_req_t;

  // answer from the edge unit
  typedef struct packed {
    logic              done;
    logic signed [1:0] turn;
  } edge_rsp_t;

endpackage

>>> rtl/pip_vertex_mem.sv
// vertex store: x and y memories, one write port and one registered read port
module pip_vertex_mem (
  input  logic                               clk,
  input  logic                               wr_en,
  input  logic [pip_pkg::ADDR_W-1:0]         wr_addr,
  input  logic signed [pip_pkg::COORD_W-1:0] wr_x,
  input  logic signed [pip_pkg::COORD_W-1:0] wr_y,
  input  logic                               rd_en,
  input  logic [pip_pkg::ADDR_W-1:0]         rd_addr,
  output logic signed [pip_pkg::COORD_W-1:0] rd_x,
  output logic signed [pip_pkg::COORD_W-1:0] rd_y
);
  import pip_pkg::*;

  logic signed [COORD_W-1:0] mem_x [MAX_VERTICES];
  logic signed [COORD_W-1:0] mem_y [MAX_VERTICES];
  logic signed [COORD_W-1:0] rd_x_r;
  logic signed [COORD_W-1:0] rd_y_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wr_addr] <= wr_x;
      mem_y[wr_addr] <= wr_y;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_x_r <= mem_x[rd_addr];
      rd_y_r <= mem_y[rd_addr];
    end
  end

  assign rd_x = rd_x_r;
  assign rd_y = rd_y_r;

endmodule

>>> rtl/pip_edge_unit.sv
// edge unit: quadrant classification and exact crossing test on one shared multiplier
module pip_edge_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  pip_pkg::edge_req_t req,
  output pip_pkg::edge_rsp_t rsp
);
  import pip_pkg::*;

  localparam logic [1:0] E_IDLE = 2'd0;
  localparam logic [1:0] E_MUL1 = 2'd1;
  localparam logic [1:0] E_MUL2 = 2'd2;
  localparam logic [1:0] E_CMP  = 2'd3;

  logic [1:0]               e_state_r, e_state_nxt;
  logic                     done_r, done_nxt;
  logic signed [1:0]        turn_r, turn_nxt;
  logic [1:0]               q0_r, q0_nxt;
  logic signed [DIFF_W-1:0] a_r, a_nxt;   // py - y0
  logic signed [DIFF_W-1:0] b_r, b_nxt;   // x1 - x0
  logic signed [DIFF_W-1:0] c_r, c_nxt;   // px - x0
  logic signed [DIFF_W-1:0] e_r, e_nxt;   // y1 - y0
  logic signed [PROD_W-1:0] lhs_r, lhs_nxt;
  logic signed [PROD_W-1:0] rhs_r, rhs_nxt;

  logic [1:0]               q0, q1;
  logic [2:0]               qd, qabs;
  logic                     dy_pos, use_ab;
  logic signed [DIFF_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;

  // quadrant around the point: left-up 0, right-up 1, right-down 2, left-down 3
  function automatic logic [1:0] quad(input logic signed [COORD_W-1:0] x,
                                      input logic signed [COORD_W-1:0] y,
                                      input logic signed [COORD_W-1:0] px,
                                      input logic signed [COORD_W-1:0] py);
    logic left, up;
    left = (x <= px);
    up   = (y > py);
    if (left) begin
      quad = up ? 2'd0 : 2'd3;
    end else begin
      quad = up ? 2'd1 : 2'd2;
    end
  endfunction

  // quadrant distance of the two endpoints
  always_comb begin
    q0   = quad(req.x0, req.y0, req.px, req.py);
    q1   = quad(req.x1, req.y1, req.px, req.py);
    qd   = {1'b0, q0} - {1'b0, q1};
    qabs = qd[2] ? (3'd0 - qd) : qd;
  end

  // shared multiplier: left side of the compare first, right side second
  assign dy_pos = !e_r[DIFF_W-1] && (e_r != '0);
  assign use_ab = (e_state_r == E_MUL1) ? dy_pos : !dy_pos;
  assign mul_a  = use_ab ? a_r : c_r;
  assign mul_b  = use_ab ? b_r : e_r;
  assign mul_p  = PROD_W'(mul_a) * PROD_W'(mul_b);

  // sequencer of one edge
  always_comb begin
    e_state_nxt = e_state_r;
    done_nxt    = 1'b0;
    turn_nxt    = turn_r;
    q0_nxt      = q0_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    c_nxt       = c_r;
    e_nxt       = e_r;
    lhs_nxt     = lhs_r;
    rhs_nxt     = rhs_r;
    case (e_state_r)
      E_IDLE: begin
        if (req.start) begin
          q0_nxt = q0;
          a_nxt  = DIFF_W'(req.py) - DIFF_W'(req.y0);
          b_nxt  = DIFF_W'(req.x1) - DIFF_W'(req.x0);
          c_nxt  = DIFF_W'(req.px) - DIFF_W'(req.x0);
          e_nxt  = DIFF_W'(req.y1) - DIFF_W'(req.y0);
          if (qabs == 3'd2) begin
            e_state_nxt = E_MUL1;
          end else begin
            done_nxt = 1'b1;
            if (qabs == 3'd3) begin
              turn_nxt = (q0 == 2'd0) ? TURN_POS : TURN_NEG;
            end else begin
              turn_nxt = TURN_ZERO;
            end
          end
        end
      end
      E_MUL1: begin
        lhs_nxt     = mul_p;
        e_state_nxt = E_MUL2;
      end
      E_MUL2: begin
        rhs_nxt     = mul_p;
        e_state_nxt = E_CMP;
      end
      E_CMP: begin
        done_nxt    = 1'b1;
        e_state_nxt = E_IDLE;
        if (lhs_r < rhs_r) begin
          turn_nxt = (q0_r <= 2'd1) ? TURN_POS : TURN_NEG;
        end else begin
          turn_nxt = TURN_ZERO;
        end
      end
      default: begin
        e_state_nxt = E_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_state_r <= E_IDLE;
      done_r    <= 1'b0;
    end else begin
      e_state_r <= e_state_nxt;
      done_r    <= done_nxt;
    end
  end

  // operand and product registers
  always_ff @(posedge clk) begin
    turn_r <= turn_nxt;
    q0_r   <= q0_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    c_r    <= c_nxt;
    e_r    <= e_nxt;
    lhs_r  <= lhs_nxt;
    rhs_r  <= rhs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.turn = turn_r;

  // a new edge only arrives when the unit is free
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> (e_state_r == E_IDLE))
    else $error("edge start while edge unit busy");

  // the unit is free again whenever it reports
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (e_state_r == E_IDLE))
    else $error("edge done while edge unit still busy");

  // opposite quadrants never have a flat edge
  a_dy_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (e_state_r == E_MUL1) |-> (e_r != '0))
    else $error("zero dy on an opposite-quadrant edge");

endmodule

>>> rtl/point_in_polygon_winding.sv
// top level: item sequencer, vertex count, winding accumulator and result register
//
//   channel | direction | ports                                             | handshake
//   in_     | input     | kind, coord_x, coord_y                            | in_valid / in_stall
//   out_    | output    | inside_res, winding_sum, vertex_total, full_error | out_valid / out_stall
//
// append, clear and unused kinds: the result passes through S_DONE to the output register.
// query on n >= 3 vertices: S_LOAD0, then S_LOAD and S_WAIT per edge, S_CLOSE for the closing
//   edge; opposite-quadrant edges also run E_MUL1, E_MUL2 and E_CMP on the shared multiplier.
// one item is worked on at a time; the next beat is taken as soon as the result sits in
//   the output register, even while out_stall holds it there.
// rst_n is synchronous; it empties the polygon. vertex memory contents are not cleared.
module point_in_polygon_winding (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [pip_pkg::KIND_W-1:0]         in_kind,
  input  logic signed [pip_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [pip_pkg::COORD_W-1:0] in_coord_y,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_inside_res,
  output logic signed [pip_pkg::SUM_W-1:0]   out_winding_sum,
  output logic [pip_pkg::TOTAL_W-1:0]        out_vertex_total,
  output logic                               out_full_error
);
  import pip_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD0 = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_CLOSE = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]                state_r, state_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [CNT_W-1:0]          idx_r, idx_nxt;
  logic                      last_r, last_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic                      full_r, full_nxt;
  logic signed [COORD_W-1:0] px_r, px_nxt;
  logic signed [COORD_W-1:0] py_r, py_nxt;
  logic signed [COORD_W-1:0] first_x_r, first_x_nxt;
  logic signed [COORD_W-1:0] first_y_r, first_y_nxt;
  logic signed [COORD_W-1:0] prev_x_r, prev_x_nxt;
  logic signed [COORD_W-1:0] prev_y_r, prev_y_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_inside_r, out_inside_nxt;
  logic signed [SUM_W-1:0]   out_sum_r, out_sum_nxt;
  logic [TOTAL_W-1:0]        out_total_r, out_total_nxt;
  logic                      out_full_r, out_full_nxt;

  logic                      wr_en, rd_en;
  logic [ADDR_W-1:0]         rd_addr;
  logic signed [COORD_W-1:0] rd_x, rd_y;
  logic signed [ACC_W-1:0]   acc_add;
  edge_req_t                 req;
  edge_rsp_t                 rsp;

  // vertex store
  pip_vertex_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[ADDR_W-1:0]),
    .wr_x    (in_coord_x),
    .wr_y    (in_coord_y),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_x    (rd_x),
    .rd_y    (rd_y)
  );

  // shared edge arithmetic
  pip_edge_unit u_edge (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  assign in_stall = (state_r != S_IDLE);
  assign acc_add  = acc_r + ACC_W'(rsp.turn);

  // item sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    last_nxt      = last_r;
    acc_nxt       = acc_r;
    full_nxt      = full_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    first_x_nxt   = first_x_r;
    first_y_nxt   = first_y_r;
    prev_x_nxt    = prev_x_r;
    prev_y_nxt    = prev_y_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_inside_nxt = out_inside_r;
    out_sum_nxt   = out_sum_r;
    out_total_nxt = out_total_r;
    out_full_nxt  = out_full_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = idx_r[ADDR_W-1:0];
    req.start     = 1'b0;
    req.x0        = prev_x_r;
    req.y0        = prev_y_r;
    req.x1        = rd_x;
    req.y1        = rd_y;
    req.px        = px_r;
    req.py        = py_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          acc_nxt   = '0;
          full_nxt  = 1'b0;
          px_nxt    = in_coord_x;
          py_nxt    = in_coord_y;
          state_nxt = S_DONE;
          case (in_kind)
            KIND_APPEND: begin
              if (count_r < CNT_W'(MAX_VERTICES)) begin
                wr_en     = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end else begin
                full_nxt = 1'b1;
              end
            end
            KIND_QUERY: begin
              if (count_r >= CNT_W'(MIN_POLY)) begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                idx_nxt   = CNT_W'(1);
                state_nxt = S_LOAD0;
              end
            end
            KIND_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      // first vertex arrives; keep it for the closing edge
      S_LOAD0: begin
        first_x_nxt = rd_x;
        first_y_nxt = rd_y;
        prev_x_nxt  = rd_x;
        prev_y_nxt  = rd_y;
        rd_en       = 1'b1;
        idx_nxt     = idx_r + CNT_W'(1);
        state_nxt   = S_LOAD;
      end
      // launch edge prev -> current and prefetch the next vertex
      S_LOAD: begin
        req.start  = 1'b1;
        prev_x_nxt = rd_x;
        prev_y_nxt = rd_y;
        last_nxt   = (idx_r == count_r);
        if (idx_r < count_r) begin
          rd_en   = 1'b1;
          idx_nxt = idx_r + CNT_W'(1);
        end
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (rsp.done) begin
          acc_nxt = acc_add;
          if (last_r) begin
            req.start = 1'b1;
            req.x1    = first_x_r;
            req.y1    = first_y_r;
            state_nxt = S_CLOSE;
          end else begin
            state_nxt = S_LOAD;
          end
        end
      end
      // closing edge last -> first
      S_CLOSE: begin
        if (rsp.done) begin
          acc_nxt   = acc_add;
          state_nxt = S_DONE;
        end
      end
      // hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_inside_nxt = (acc_r != '0);
          out_sum_nxt    = SUM_W'(acc_r);
          out_total_nxt  = TOTAL_W'(count_r);
          out_full_nxt   = full_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    last_r       <= last_nxt;
    acc_r        <= acc_nxt;
    full_r       <= full_nxt;
    px_r         <= px_nxt;
    py_r         <= py_nxt;
    first_x_r    <= first_x_nxt;
    first_y_r    <= first_y_nxt;
    prev_x_r     <= prev_x_nxt;
    prev_y_r     <= prev_y_nxt;
    out_inside_r <= out_inside_nxt;
    out_sum_r    <= out_sum_nxt;
    out_total_r  <= out_total_nxt;
    out_full_r   <= out_full_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_inside_res   = out_inside_r;
  assign out_winding_sum  = out_sum_r;
  assign out_vertex_total = out_total_r;
  assign out_full_error   = out_full_r;

  // vertex count stays within the store
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_VERTICES))
    else $error("vertex count beyond store size");

  // edge results only come back while a query waits for them
  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> (state_r == S_WAIT || state_r == S_CLOSE))
    else $error("unexpected edge result");

  // inside flag agrees with the winding sum on every result beat
  a_inside_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_inside_r == (out_sum_r != '0)))
    else $error("inside flag disagrees with winding sum");

  // a rejected append only happens on a full store
  a_full_reason: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && full_r) |-> (count_r == CNT_W'(MAX_VERTICES)))
    else $error("full error with room left");

endmodule

>>> bench/point_in_polygon_winding_tb.sv
`timescale 1ns / 100ps
// self-checking testbench of the winding-number point-in-polygon block
module point_in_polygon_winding_tb;
  import pip_pkg::*;

  // item kind that the block leaves unused
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam int QUIET_LIMIT  = 20000;
  localparam int REPORT_LIMIT = 10;
  localparam int DRAIN_CYCLES = 40;

  // one predicted result beat
  typedef struct {
    logic                    in_poly;
    logic signed [SUM_W-1:0] sum;
    logic [TOTAL_W-1:0]      total;
    logic                    full;
  } poly_answer_t;

  logic                      clk        = 1'b0;
  logic                      rst_n      = 1'b0;
  logic                      in_valid   = 1'b0;
  logic                      in_stall;
  logic [KIND_W-1:0]         in_kind    = KIND_APPEND;
  logic signed [COORD_W-1:0] in_coord_x = '0;
  logic signed [COORD_W-1:0] in_coord_y = '0;
  logic                      out_valid;
  logic                      out_stall  = 1'b0;
  logic                      out_inside_res;
  logic signed [SUM_W-1:0]   out_winding_sum;
  logic [TOTAL_W-1:0]        out_vertex_total;
  logic                      out_full_error;

  // shadow copy of the polygon
  logic signed [COORD_W-1:0] shadow_x [MAX_VERTICES];
  logic signed [COORD_W-1:0] shadow_y [MAX_VERTICES];
  int                        shadow_count = 0;

  poly_answer_t pending_answers [$];
  int           mismatches  = 0;
  int           items_sent  = 0;
  int           quiet_cycles = 0;
  int           stall_left  = 0;
  bit           idle_on     = 1'b0;

  point_in_polygon_winding dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_coord_x       (in_coord_x),
    .in_coord_y       (in_coord_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_inside_res   (out_inside_res),
    .out_winding_sum  (out_winding_sum),
    .out_vertex_total (out_vertex_total),
    .out_full_error   (out_full_error)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // quadrant of a vertex around the point: left-up 0, right-up 1, right-down 2, left-down 3
  function automatic int quadrant_of(logic signed [COORD_W-1:0] x, y, px, py);
    if (x <= px) return (y > py) ? 0 : 3;
    return (y > py) ? 1 : 2;
  endfunction

  // turn added by one edge
  function automatic int edge_turn(logic signed [COORD_W-1:0] x0, y0, x1, y1, px, py);
    int q0, q1, qgap;
    logic signed [PROD_W+1:0] dx, dy, ex, ey, lhs, rhs;
    bit left;
    q0   = quadrant_of(x0, y0, px, py);
    q1   = quadrant_of(x1, y1, px, py);
    qgap = (q0 > q1) ? q0 - q1 : q1 - q0;
    if (qgap <= 1) return 0;
    if (qgap == 3) return (q0 == 0) ? 1 : -1;
    // opposite quadrants: exact crossing test by cross-multiplication
    dx   = x1 - x0;
    dy   = y1 - y0;
    ex   = px - x0;
    ey   = py - y0;
    lhs  = ey * dx;
    rhs  = ex * dy;
    left = (dy > 0) ? (lhs < rhs) : (rhs < lhs);
    if (!left) return 0;
    return (q0 <= 1) ? 1 : -1;
  endfunction

  // expected result of one item, updating the shadow polygon
  function automatic poly_answer_t predict_answer(logic [KIND_W-1:0] kind,
                                                  logic signed [COORD_W-1:0] cx, cy);
    poly_answer_t ans;
    int sum, i, j;
    sum      = 0;
    ans.full = 1'b0;
    case (kind)
      KIND_APPEND: begin
        if (shadow_count < MAX_VERTICES) begin
          shadow_x[shadow_count] = cx;
          shadow_y[shadow_count] = cy;
          shadow_count++;
        end else begin
          ans.full = 1'b1;
        end
      end
      KIND_QUERY: begin
        if (shadow_count >= MIN_POLY) begin
          for (i = 0; i < shadow_count; i++) begin
            j = (i + 1 == shadow_count) ? 0 : i + 1;
            sum += edge_turn(shadow_x[i], shadow_y[i], shadow_x[j], shadow_y[j], cx, cy);
          end
        end
      end
      KIND_CLEAR: shadow_count = 0;
      default: ;
    endcase
    ans.in_poly = (sum != 0);
    ans.sum     = SUM_W'(sum);
    ans.total   = TOTAL_W'(shadow_count);
    return ans;
  endfunction

  // random coordinate at one of four scales
  function automatic logic signed [COORD_W-1:0] pick_coord(int scale);
    case (scale)
      0: return int'($urandom_range(0, 16)) - 8;
      1: return int'($urandom_range(0, 2000)) - 1000;
      2: return $urandom;
      default: begin
        case ($urandom_range(0, 6))
          0: return COORD_MIN;
          1: return COORD_MIN + 1;
          2: return -1;
          3: return 0;
          4: return 1;
          5: return COORD_MAX - 1;
          default: return COORD_MAX;
        endcase
      end
    endcase
  endfunction

  function automatic logic signed [COORD_W-1:0] midpoint(logic signed [COORD_W-1:0] a, b);
    logic signed [COORD_W:0] total;
    total = a + b;
    return total[COORD_W:1];
  endfunction

  // drive one beat, hold it until taken, then record its expected result
  task automatic send_item(input logic [KIND_W-1:0] kind,
                           input logic signed [COORD_W-1:0] cx, cy);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_kind    <= kind;
    in_coord_x <= cx;
    in_coord_y <= cy;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_answers.insert(pending_answers.size(), predict_answer(kind, cx, cy));
    items_sent++;
  endtask

  // hold off the sender until every result is back
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // field extremes, polygons below three vertices, exact edge hits, unused kind
  task automatic test_directed_extremes();
    send_item(KIND_QUERY, 0, 0);
    send_item(KIND_APPEND, COORD_MIN, COORD_MIN);
    send_item(KIND_QUERY, 0, 0);
    send_item(KIND_APPEND, COORD_MAX, COORD_MIN);
    send_item(KIND_QUERY, 0, 0);
    send_item(KIND_APPEND, COORD_MAX, COORD_MAX);
    send_item(KIND_APPEND, COORD_MIN, COORD_MAX);
    send_item(KIND_QUERY, 0, 0);
    send_item(KIND_QUERY, COORD_MAX, COORD_MAX);
    send_item(KIND_QUERY, COORD_MIN, COORD_MIN);
    send_item(KIND_QUERY, COORD_MIN, 0);
    send_item(KIND_QUERY, COORD_MAX, -1);
    send_item(KIND_SPARE, -1, -1);
    send_item(KIND_CLEAR, COORD_MAX, COORD_MIN);
    send_item(KIND_QUERY, 0, 0);
    // triangle whose first edge runs exactly through the query point
    send_item(KIND_APPEND, -2, 2);
    send_item(KIND_APPEND, 2, -2);
    send_item(KIND_APPEND, 3, 3);
    send_item(KIND_QUERY, 0, 0);
    send_item(KIND_QUERY, 1, -1);
    send_item(KIND_QUERY, 1, 0);
    send_item(KIND_QUERY, -1, 0);
    send_item(KIND_CLEAR, 0, 0);
  endtask

  // fill the store with a wound triangle, query it, then overfill
  task automatic test_full_store();
    int i;
    idle_on <= 1'b1;
    send_item(KIND_CLEAR, 0, 0);
    for (i = 0; i < MAX_VERTICES; i++) begin
      case (i % 3)
        0: send_item(KIND_APPEND, -5, 10);
        1: send_item(KIND_APPEND, -5, -10);
        default: send_item(KIND_APPEND, 10, 0);
      endcase
    end
    send_item(KIND_QUERY, 0, 0);
    send_item(KIND_QUERY, 100, 100);
    send_item(KIND_APPEND, 1, 1);
    send_item(KIND_SPARE, 0, 0);
    send_item(KIND_QUERY, -1, 1);
    send_item(KIND_CLEAR, 0, 0);
    wait_results_drained();
  endtask

  // random polygons with random queries, some noise in between
  task automatic test_random_polygons(input int target, input bit allow_idle);
    int scale, n, pick;
    logic signed [COORD_W-1:0] qx, qy;
    while (items_sent < target) begin
      idle_on <= allow_idle && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 19) == 0) begin
        // noise: any kind, any coordinates
        repeat ($urandom_range(1, 6)) send_item(KIND_W'($urandom), $urandom, $urandom);
      end else begin
        scale = $urandom_range(0, 3);
        if (shadow_count > 20 || $urandom_range(0, 7) != 0)
          send_item(KIND_CLEAR, $urandom, $urandom);
        pick = $urandom_range(0, 19);
        if (pick == 0) n = $urandom_range(11, 60);
        else if (pick < 3) n = $urandom_range(0, 2);
        else n = $urandom_range(3, 10);
        repeat (n) send_item(KIND_APPEND, pick_coord(scale), pick_coord(scale));
        repeat ($urandom_range(1, 6)) begin
          pick = $urandom_range(0, 3);
          if (pick == 0 && shadow_count > 0) begin
            // on a vertex
            pick = $urandom_range(0, shadow_count - 1);
            qx   = shadow_x[pick];
            qy   = shadow_y[pick];
          end else if (pick == 1 && shadow_count > 1) begin
            // on or near an edge
            pick = $urandom_range(0, shadow_count - 2);
            qx   = midpoint(shadow_x[pick], shadow_x[pick+1]);
            qy   = midpoint(shadow_y[pick], shadow_y[pick+1]);
          end else begin
            qx = pick_coord(scale);
            qy = pick_coord(scale);
          end
          send_item(KIND_QUERY, qx, qy);
          if ($urandom_range(0, 15) == 0) send_item(KIND_SPARE, $urandom, $urandom);
        end
        if ($urandom_range(0, 9) == 0) wait_results_drained();
      end
    end
  endtask

  task automatic test_without_idling(input int target);
    test_random_polygons(target, 1'b0);
  endtask

  // receiver stall bursts
  always @(posedge clk) begin
    if (!idle_on || !rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 9) == 0) stall_left <= $urandom_range(1, 13);
    end
  end

  // result check and watchdog
  always @(posedge clk) begin : check_results
    poly_answer_t want;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (pending_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected beat: inside=%0b sum=%0d total=%0d full=%0b",
                     out_inside_res, out_winding_sum, out_vertex_total, out_full_error);
        end else begin
          want = pending_answers.pop_front();
          if (out_inside_res !== want.in_poly || out_winding_sum !== want.sum ||
              out_vertex_total !== want.total || out_full_error !== want.full) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("mismatch: want inside=%0b sum=%0d total=%0d full=%0b, got %0b %0d %0d %0b",
                       want.in_poly, want.sum, want.total, want.full, out_inside_res,
                       out_winding_sum, out_vertex_total, out_full_error);
          end
        end
      end
    end
  end

  // test sequence
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_extremes();
    test_full_store();
    test_random_polygons(1250, 1'b1);
    test_without_idling(1400);
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/pip_pkg.sv
rtl/pip_vertex_mem.sv
rtl/pip_edge_unit.sv
rtl/point_in_polygon_winding.sv
bench/point_in_polygon_winding_tb.sv
